FILE: rtl/core/gfit_pkg.sv
package gfit_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    localparam logic [1:0] CMD_FIND  = 2'd0;
    localparam logic [1:0] CMD_PLACE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic [3:0] pad;
        logic [3:0] place_col;
        logic [3:0] place_row;
        logic [4:0] rect_width;
        logic [4:0] rect_height;
        logic [1:0] command;
    } in_word_t;

    typedef struct packed {
        logic [4:0] pad;
        logic       grid_empty;
        logic [8:0] free_cells;
        logic [3:0] found_col;
        logic [3:0] found_row;
        logic       status;
    } out_word_t;

endpackage

FILE: rtl/core/grid_rectangle_first_fit_core.sv
// Clear, zero-size and out-of-range requests go straight to the result without
// reading the row memory. One request at a time; find reads the grid rows in order
// from row 0, each at most once, and stops at the first fit; place reads its rows
// once to check and, if all are free, once more to mark them.
// Reset (aresetn low, synchronous) frees every cell at once through per-row valid
// bits and sets the free count to the grid area; no clearing pass.
module grid_rectangle_first_fit_core
    import gfit_pkg::*;
#(
    parameter int GRID_SIZE = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // command, rect_height, rect_width, place_row, place_col
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, found_row, found_col, free_cells, grid_empty
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW     = $clog2(GRID_SIZE);
    localparam int RW     = $clog2(GRID_SIZE + 1);
    localparam int NW     = $clog2(2 * GRID_SIZE + 32);
    localparam int FW     = $clog2(GRID_SIZE * GRID_SIZE + 1);
    localparam int AREA_W = 2 * RW;

    localparam logic [FW-1:0] FULL_COUNT = FW'(GRID_SIZE * GRID_SIZE);
    localparam logic [NW-1:0] GN         = NW'(GRID_SIZE);
    localparam logic [AW-1:0] LAST_ROW   = AW'(GRID_SIZE - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    in_word_t             in_w;
    logic [NW-1:0]        h_in;
    logic [NW-1:0]        w_in;
    logic [NW-1:0]        pr_in;
    logic [NW-1:0]        pc_in;
    logic [GRID_SIZE-1:0] wmask_in;

    logic [2:0]           state_reg, state_next;
    logic [NW-1:0]        h_reg, h_next;
    logic [NW-1:0]        w_reg, w_next;
    logic [GRID_SIZE-1:0] mask_reg, mask_next;
    logic [AW-1:0]        first_reg, first_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [AW-1:0]        iss_row_reg, iss_row_next;
    logic                 iss_on_reg, iss_on_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [AW-1:0]        rd_row_reg, rd_row_next;
    logic                 rd_last_reg, rd_last_next;
    logic [RW-1:0]        run_reg [GRID_SIZE];
    logic [RW-1:0]        run_next [GRID_SIZE];
    logic [FW-1:0]        free_reg, free_next;
    logic [AREA_W-1:0]    area_reg, area_next;
    logic                 res_status_reg, res_status_next;
    logic [3:0]           res_row_reg, res_row_next;
    logic [3:0]           res_col_reg, res_col_next;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_data_reg, m_data_next;

    logic                 rd_en;
    logic                 wr_en;
    logic                 clr;
    logic                 work;
    logic [GRID_SIZE-1:0] rd_data;
    logic [GRID_SIZE-1:0] fit_row;
    logic [GRID_SIZE-1:0] hit;
    logic [RW-1:0]        run_inc [GRID_SIZE];
    logic [AW-1:0]        hit_col;
    logic                 place_bad;

    gfit_row_mem #(
        .GRID_SIZE (GRID_SIZE)
    ) u_row_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (iss_row_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (rd_row_reg),
        .wr_data (rd_data | mask_reg),
        .clr     (clr)
    );

    assign in_w     = in_word_t'(s_tdata);
    assign h_in     = NW'(in_w.rect_height);
    assign w_in     = NW'(in_w.rect_width);
    assign pr_in    = NW'(in_w.place_row);
    assign pc_in    = NW'(in_w.place_col);
    assign wmask_in = ~({GRID_SIZE{1'b1}} << w_in);

    // one lane per start column: count consecutive rows that are free there
    always_comb begin
        for (int j = 0; j < GRID_SIZE; j++) begin
            run_inc[j] = run_reg[j] + RW'(1);
            fit_row[j] = ((NW'(j) + w_reg) <= GN) && ((rd_data & (mask_reg << j)) == '0);
            hit[j]     = fit_row[j] && (NW'(run_inc[j]) >= h_reg);
        end
        hit_col = '0;
        for (int j = GRID_SIZE - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_col = AW'(j);
            end
        end
    end

    assign place_bad = (rd_data & mask_reg) != '0;
    assign work      = (state_reg == S_SCAN) || (state_reg == S_CHECK) ||
                       (state_reg == S_WRITE);
    assign area_next = AREA_W'(RW'(h_reg)) * AREA_W'(RW'(w_reg));

    always_comb begin
        state_next      = state_reg;
        h_next          = h_reg;
        w_next          = w_reg;
        mask_next       = mask_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        iss_row_next    = iss_row_reg;
        iss_on_next     = iss_on_reg;
        run_next        = run_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        clr             = 1'b0;

        if (work && iss_on_reg) begin
            rd_en        = 1'b1;
            iss_row_next = iss_row_reg + AW'(1);
            iss_on_next  = (iss_row_reg != last_reg);
        end
        rd_pend_next = rd_en;
        rd_row_next  = iss_row_reg;
        rd_last_next = (iss_row_reg == last_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    h_next          = h_in;
                    w_next          = w_in;
                    res_status_next = ST_REFUSED;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    state_next      = S_DONE;
                    unique case (in_w.command)
                        CMD_FIND: begin
                            mask_next = wmask_in;
                            if ((h_in <= GN) && (w_in <= GN)) begin
                                if ((h_in == '0) || (w_in == '0)) begin
                                    res_status_next = ST_OK;
                                end else begin
                                    state_next   = S_SCAN;
                                    iss_row_next = '0;
                                    last_next    = LAST_ROW;
                                    iss_on_next  = 1'b1;
                                    for (int j = 0; j < GRID_SIZE; j++) begin
                                        run_next[j] = '0;
                                    end
                                end
                            end
                        end
                        CMD_PLACE: begin
                            mask_next = wmask_in << pc_in;
                            if (((pr_in + h_in) <= GN) && ((pc_in + w_in) <= GN)) begin
                                if ((h_in == '0) || (w_in == '0)) begin
                                    res_status_next = ST_OK;
                                end else begin
                                    state_next   = S_CHECK;
                                    iss_row_next = AW'(pr_in);
                                    first_next   = AW'(pr_in);
                                    last_next    = AW'(pr_in + h_in - NW'(1));
                                    iss_on_next  = 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            clr             = 1'b1;
                            free_next       = FULL_COUNT;
                            res_status_next = ST_OK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_pend_reg) begin
                    for (int j = 0; j < GRID_SIZE; j++) begin
                        run_next[j] = fit_row[j] ? run_inc[j] : '0;
                    end
                    if (hit != '0) begin
                        res_status_next = ST_OK;
                        res_row_next    = 4'(NW'(rd_row_reg) + NW'(1) - h_reg);
                        res_col_next    = 4'(hit_col);
                        iss_on_next     = 1'b0;
                        state_next      = S_DONE;
                    end else if (rd_last_reg) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                if (rd_pend_reg) begin
                    if (place_bad) begin
                        iss_on_next = 1'b0;
                        state_next  = S_DONE;
                    end else if (rd_last_reg) begin
                        iss_row_next = first_reg;
                        iss_on_next  = 1'b1;
                        state_next   = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                if (rd_pend_reg) begin
                    wr_en = 1'b1;
                    if (rd_last_reg) begin
                        free_next       = free_reg - FW'(area_reg);
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.pad        = '0;
                    m_data_next.status     = res_status_reg;
                    m_data_next.found_row  = res_row_reg;
                    m_data_next.found_col  = res_col_reg;
                    m_data_next.free_cells = 9'(free_reg);
                    m_data_next.grid_empty = (free_reg == FULL_COUNT);
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            iss_on_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            free_reg    <= FULL_COUNT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iss_on_reg  <= iss_on_next;
            rd_pend_reg <= rd_pend_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg          <= h_next;
        w_reg          <= w_next;
        mask_reg       <= mask_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        iss_row_reg    <= iss_row_next;
        rd_row_reg     <= rd_row_next;
        rd_last_reg    <= rd_last_next;
        run_reg        <= run_next;
        area_reg       <= area_next;
        res_status_reg <= res_status_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        m_data_reg     <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !rd_pend_reg)
        else $error("row read still in flight while idle");

    a_write_only_marking: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ((state_reg == S_WRITE) && rd_pend_reg))
        else $error("row write outside the marking pass");

    a_free_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (free_reg <= FULL_COUNT))
        else $error("free count beyond grid area");

endmodule

FILE: rtl/core/gfit_row_mem.sv
module gfit_row_mem #(
    parameter int GRID_SIZE = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(GRID_SIZE)-1:0]  rd_addr,
    output logic [GRID_SIZE-1:0]          rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(GRID_SIZE)-1:0]  wr_addr,
    input  logic [GRID_SIZE-1:0]          wr_data,
    input  logic                          clr
);

    logic [GRID_SIZE-1:0] mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] data_reg;
    logic                 hit_reg;
    logic [GRID_SIZE-1:0] valid_reg;
    logic [GRID_SIZE-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
            hit_reg  <= valid_reg[rd_addr];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        if (clr) begin
            valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // rows never written since reset or clear read as free
    assign rd_data = hit_reg ? data_reg : '0;

endmodule

FILE: bench/grid_rectangle_first_fit_core_test.sv
module grid_rectangle_first_fit_core_test
    import gfit_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID         = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 700;
    localparam int STEADY_FROM  = 900;
    localparam int STEADY_TO    = 1100;
    localparam int TAIL_CYCLES  = 2 * GRID + 8;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct {
        in_word_t  req;
        bit        known;
        out_word_t res;
    } directed_row_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic             holdoff  = 1'b0;
    logic             steady   = 1'b0;

    logic [GRID-1:0]  occupied_rows [GRID];
    int               free_cells_left;
    out_word_t        expected_results [$];
    directed_row_t    directed_rows [$];
    int               sent_count = 0;
    int               result_count = 0;
    int               mismatches = 0;

    grid_rectangle_first_fit_core #(
        .GRID_SIZE(GRID)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic in_word_t make_req(logic [1:0] cmd, int h, int w, int r, int c);
        in_word_t req;
        req             = '0;
        req.command     = cmd;
        req.rect_height = 5'(h);
        req.rect_width  = 5'(w);
        req.place_row   = 4'(r);
        req.place_col   = 4'(c);
        return req;
    endfunction

    function automatic out_word_t make_res(logic st, int r, int c, int free_n, bit empty);
        out_word_t res;
        res            = '0;
        res.status     = st;
        res.found_row  = 4'(r);
        res.found_col  = 4'(c);
        res.free_cells = 9'(free_n);
        res.grid_empty = empty;
        return res;
    endfunction

    function automatic void free_whole_grid();
        for (int i = 0; i < GRID; i++) begin
            occupied_rows[i] = '0;
        end
        free_cells_left = GRID * GRID;
    endfunction

    function automatic logic [GRID-1:0] column_span(int w, int c);
        logic [31:0] span;
        span = ((32'd1 << w) - 32'd1) << c;
        return span[GRID-1:0];
    endfunction

    function automatic bit rect_fits(int h, int w, int r, int c);
        logic [GRID-1:0] span;
        if (r + h > GRID || c + w > GRID) begin
            return 1'b0;
        end
        span = column_span(w, c);
        for (int i = r; i < r + h; i++) begin
            if ((occupied_rows[i] & span) != '0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic out_word_t apply_grid_request(in_word_t req);
        out_word_t       res;
        logic [GRID-1:0] span;
        bit              hit;
        int              h, w, r, c;
        res        = '0;
        res.status = ST_REFUSED;
        h = int'(req.rect_height);
        w = int'(req.rect_width);
        r = int'(req.place_row);
        c = int'(req.place_col);
        case (req.command)
            CMD_FIND: begin
                hit = 1'b0;
                if (h <= GRID && w <= GRID) begin
                    for (int i = 0; !hit && i + h <= GRID; i++) begin
                        for (int j = 0; !hit && j + w <= GRID; j++) begin
                            if (rect_fits(h, w, i, j)) begin
                                hit           = 1'b1;
                                res.status    = ST_OK;
                                res.found_row = 4'(i);
                                res.found_col = 4'(j);
                            end
                        end
                    end
                end
            end
            CMD_PLACE: begin
                if (rect_fits(h, w, r, c)) begin
                    span = column_span(w, c);
                    for (int i = r; i < r + h; i++) begin
                        occupied_rows[i] |= span;
                    end
                    free_cells_left -= h * w;
                    res.status = ST_OK;
                end
            end
            CMD_CLEAR: begin
                free_whole_grid();
                res.status = ST_OK;
            end
            default: begin
            end
        endcase
        res.free_cells = 9'(free_cells_left);
        res.grid_empty = (free_cells_left == GRID * GRID);
        return res;
    endfunction

    function automatic int rand_side();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return $urandom_range(1, 4);
        end else if (pick < 95) begin
            return $urandom_range(1, GRID);
        end else if (pick < 97) begin
            return 0;
        end
        return $urandom_range(GRID + 1, 31);
    endfunction

    task automatic send_request(input in_word_t req, input bit known, input out_word_t typed,
                                output out_word_t predicted);
        if (!steady && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tdata  <= req;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_grid_request(req);
        expected_results.push_back(known ? typed : predicted);
        sent_count++;
        steady <= (sent_count >= STEADY_FROM && sent_count < STEADY_TO);
    endtask

    always @(posedge aclk) begin : result_check
        out_word_t got;
        out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("word %0d arrived with nothing outstanding: %h",
                             result_count, m_tdata);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status || got.found_row != want.found_row ||
                    got.found_col != want.found_col || got.free_cells != want.free_cells ||
                    got.grid_empty != want.grid_empty) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d: expected st %0d row %0d col %0d free %0d empty %0d,",
                                 result_count, want.status, want.found_row, want.found_col,
                                 want.free_cells, want.grid_empty);
                        $display("          got      st %0d row %0d col %0d free %0d empty %0d",
                                 got.status, got.found_row, got.found_col,
                                 got.free_cells, got.grid_empty);
                    end
                end
            end
            result_count++;
        end
        if (holdoff) begin
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 11);
        end
    end

    initial begin
        while (sent_count < HOLD_AT) @(posedge aclk);
        holdoff <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holdoff <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("grid_rectangle_first_fit_core: mismatch");
        $finish;
    end

    initial begin
        in_word_t  req;
        out_word_t got_back;
        int        pick, h, w, random_sent;
        free_whole_grid();

        directed_rows.push_back('{make_req(CMD_FIND, 1, 1, 0, 0), 1, make_res(ST_OK, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_FIND, 16, 16, 0, 0), 1,
                                  make_res(ST_OK, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_FIND, 17, 1, 0, 0), 1,
                                  make_res(ST_REFUSED, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_FIND, 1, 31, 9, 6), 1,
                                  make_res(ST_REFUSED, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_FIND, 0, 0, 5, 5), 1, make_res(ST_OK, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_PLACE, 0, 5, 3, 4), 1,
                                  make_res(ST_OK, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_PLACE, 16, 16, 0, 0), 1,
                                  make_res(ST_OK, 0, 0, 0, 0)});
        directed_rows.push_back('{make_req(CMD_FIND, 1, 1, 0, 0), 1,
                                  make_res(ST_REFUSED, 0, 0, 0, 0)});
        directed_rows.push_back('{make_req(CMD_FIND, 0, 1, 0, 0), 1, make_res(ST_OK, 0, 0, 0, 0)});
        directed_rows.push_back('{make_req(CMD_PLACE, 1, 1, 15, 15), 1,
                                  make_res(ST_REFUSED, 0, 0, 0, 0)});
        directed_rows.push_back('{make_req(CMD_UNUSED, 1, 1, 0, 0), 1,
                                  make_res(ST_REFUSED, 0, 0, 0, 0)});
        directed_rows.push_back('{make_req(CMD_CLEAR, 0, 0, 0, 0), 1,
                                  make_res(ST_OK, 0, 0, 256, 1)});
        directed_rows.push_back('{make_req(CMD_PLACE, 1, 1, 15, 15), 1,
                                  make_res(ST_OK, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_PLACE, 2, 1, 15, 0), 1,
                                  make_res(ST_REFUSED, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_PLACE, 1, 2, 0, 15), 1,
                                  make_res(ST_REFUSED, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_PLACE, 31, 31, 15, 15), 1,
                                  make_res(ST_REFUSED, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_FIND, 16, 16, 0, 0), 1,
                                  make_res(ST_REFUSED, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_FIND, 16, 15, 0, 0), 1,
                                  make_res(ST_OK, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_FIND, 1, 16, 0, 0), 1,
                                  make_res(ST_OK, 0, 0, 255, 0)});
        directed_rows.push_back('{make_req(CMD_PLACE, 4, 4, 0, 0), 1,
                                  make_res(ST_OK, 0, 0, 239, 0)});
        directed_rows.push_back('{make_req(CMD_FIND, 4, 13, 0, 0), 0, '0});
        directed_rows.push_back('{make_req(CMD_FIND, 3, 3, 0, 0), 0, '0});
        directed_rows.push_back('{make_req(CMD_PLACE, 3, 3, 0, 4), 0, '0});
        directed_rows.push_back('{make_req(CMD_UNUSED, 31, 31, 15, 15), 1,
                                  make_res(ST_REFUSED, 0, 0, 230, 0)});
        directed_rows.push_back('{make_req(CMD_CLEAR, 31, 31, 15, 15), 1,
                                  make_res(ST_OK, 0, 0, 256, 1)});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req, directed_rows[k].known,
                         directed_rows[k].res, got_back);
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (sent_count >= DRAIN_AT && sent_count < DRAIN_AT + 3) begin
                s_tvalid <= 1'b0;
                while (expected_results.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(99);
            if (pick < 4 || (free_cells_left < 24 && pick < 30)) begin
                req = make_req(CMD_CLEAR, $urandom_range(31), $urandom_range(31),
                               $urandom_range(15), $urandom_range(15));
            end else if (pick < 6) begin
                req = make_req(CMD_UNUSED, $urandom_range(31), $urandom_range(31),
                               $urandom_range(15), $urandom_range(15));
            end else if (pick < 12) begin
                req = make_req(2'($urandom_range(3)), $urandom_range(31), $urandom_range(31),
                               $urandom_range(15), $urandom_range(15));
            end else if (pick < 62) begin
                h   = rand_side();
                w   = rand_side();
                req = make_req(CMD_FIND, h, w, $urandom_range(15), $urandom_range(15));
                send_request(req, 1'b0, '0, got_back);
                random_sent++;
                if (got_back.status != ST_OK || $urandom_range(99) >= 85) begin
                    continue;
                end
                req = make_req(CMD_PLACE, h, w, got_back.found_row, got_back.found_col);
            end else begin
                req = make_req(CMD_PLACE, rand_side(), rand_side(),
                               $urandom_range(15), $urandom_range(15));
            end
            send_request(req, 1'b0, '0, got_back);
            random_sent++;
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("grid_rectangle_first_fit_core: match");
        end else begin
            $display("grid_rectangle_first_fit_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/gfit_pkg.sv
rtl/core/gfit_row_mem.sv
rtl/core/grid_rectangle_first_fit_core.sv
bench/grid_rectangle_first_fit_core_test.sv
